// ----- rtl/core/psr_pkg.sv -----
package psr_pkg;

	// Field widths and page geometry
	localparam int SPACE_W    = 14;
	localparam int XACT_BITS  = 32;
	localparam int PAGE_BYTES = 8192;

	// Signed working width: holds a sum or difference of two space values
	localparam int CALC_W = SPACE_W + 3;

	localparam logic signed [CALC_W-1:0] PAGE_LIM = CALC_W'(PAGE_BYTES);

	// Operation codes
	localparam logic [1:0] ACT_RELEASE      = 2'd0;
	localparam logic [1:0] ACT_ACQUIRE      = 2'd1;
	localparam logic [1:0] ACT_UNDO_RELEASE = 2'd2;
	localparam logic [1:0] ACT_UNDO_ACQUIRE = 2'd3;

	// One request: operation plus the page header it works on
	typedef struct packed {
		logic [1:0]           action;
		logic [XACT_BITS-1:0] xact_id;
		logic [SPACE_W-1:0]   amount;
		logic [SPACE_W-1:0]   amount_nonreserved;
		logic [SPACE_W-1:0]   free_space;
		logic [SPACE_W-1:0]   reserved;
		logic [SPACE_W-1:0]   private_reserve;
		logic [XACT_BITS-1:0] youngest;
		logic [XACT_BITS-1:0] min_active_xact;
	} psr_item_t;

	// One response: updated header and status flags
	typedef struct packed {
		logic [SPACE_W-1:0]   free_space;
		logic [SPACE_W-1:0]   reserved;
		logic [SPACE_W-1:0]   private_reserve;
		logic [XACT_BITS-1:0] youngest;
		logic                 alloc_ok;
		logic                 page_updated;
	} psr_result_t;

	// Zero-extend a space value into the signed working width.
	function automatic logic signed [CALC_W-1:0] to_calc(input logic [SPACE_W-1:0] v);
		return signed'(CALC_W'(v));
	endfunction

	// Saturate a working value to the range 0 to PAGE_BYTES.
	function automatic logic [SPACE_W-1:0] clamp_space(input logic signed [CALC_W-1:0] v);
		logic [SPACE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > PAGE_LIM) begin
			r = PAGE_LIM[SPACE_W-1:0];
		end else begin
			r = v[SPACE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/psr_calc.sv -----
module psr_calc (
	input  psr_pkg::psr_item_t                 item,
	input  logic [psr_pkg::XACT_BITS-1:0]      cache_min,
	output psr_pkg::psr_result_t               result,
	output logic [psr_pkg::XACT_BITS-1:0]      cache_min_nxt
);
	import psr_pkg::*;

	logic                        active;
	logic                        stale_chk;
	logic                        stale_old;
	logic                        refresh;
	logic                        stale;
	logic [XACT_BITS-1:0]        yg_a;
	logic [SPACE_W-1:0]          rs_a;
	logic [SPACE_W-1:0]          pr_a;
	logic signed [CALC_W-1:0]    fr_c;
	logic signed [CALC_W-1:0]    rs_c;
	logic signed [CALC_W-1:0]    pr_c;
	logic signed [CALC_W-1:0]    amt_c;
	logic signed [CALC_W-1:0]    nonres_c;
	logic signed [CALC_W-1:0]    avail;
	logic signed [CALC_W-1:0]    avail_own;
	logic signed [CALC_W-1:0]    inres;
	logic                        owner;

	// Stale reservation check, refreshing the cached minimum only when needed
	always_comb begin
		active    = (item.amount != '0);
		stale_chk = active && (item.action == ACT_RELEASE || item.action == ACT_ACQUIRE);
		stale_old = cache_min > item.youngest;
		refresh   = stale_chk && !stale_old && (item.xact_id > item.youngest);
		cache_min_nxt = refresh ? item.min_active_xact : cache_min;
		stale = stale_chk && (stale_old || (refresh && (item.min_active_xact > item.youngest)));
		yg_a  = stale ? '0 : item.youngest;
		rs_a  = stale ? '0 : item.reserved;
		pr_a  = stale ? '0 : item.private_reserve;
	end

	// Working values in the signed width
	always_comb begin
		fr_c      = to_calc(item.free_space);
		rs_c      = to_calc(rs_a);
		pr_c      = to_calc(pr_a);
		amt_c     = to_calc(item.amount);
		nonres_c  = to_calc(item.amount_nonreserved);
		owner     = (yg_a == item.xact_id);
		avail     = fr_c - rs_c;
		avail_own = avail + (owner ? pr_c : '0);
		inres     = amt_c - nonres_c;
	end

	// Header update for each operation
	always_comb begin
		result.free_space      = item.free_space;
		result.reserved        = rs_a;
		result.private_reserve = pr_a;
		result.youngest        = yg_a;
		result.alloc_ok        = (item.action == ACT_ACQUIRE);
		result.page_updated    = stale;
		if (active) begin
			unique case (item.action)
				ACT_RELEASE: begin
					result.free_space   = clamp_space(fr_c + amt_c);
					result.reserved     = clamp_space(rs_c + amt_c);
					result.page_updated = 1'b1;
					if (owner) begin
						result.private_reserve = clamp_space(pr_c + amt_c);
					end else if (item.xact_id > yg_a) begin
						result.youngest        = item.xact_id;
						result.private_reserve = clamp_space(amt_c);
					end
				end
				ACT_ACQUIRE: begin
					if (nonres_c > avail) begin
						result.alloc_ok = 1'b0;
					end else begin
						if (owner) begin
							result.page_updated = 1'b1;
						end
						if (amt_c > avail_own) begin
							result.alloc_ok = 1'b0;
						end else begin
							result.free_space   = clamp_space(fr_c - amt_c);
							result.page_updated = 1'b1;
							if (owner) begin
								if (inres > pr_c) begin
									result.reserved        = clamp_space(rs_c - pr_c);
									result.private_reserve = '0;
								end else begin
									result.reserved        = clamp_space(rs_c - inres);
									result.private_reserve = clamp_space(pr_c - inres);
								end
							end
						end
					end
				end
				ACT_UNDO_RELEASE: begin
					result.page_updated = 1'b1;
					result.free_space   = clamp_space(fr_c - amt_c);
					result.reserved     = clamp_space(rs_c - amt_c);
					if (owner) begin
						result.private_reserve = clamp_space(pr_c - amt_c);
					end
				end
				ACT_UNDO_ACQUIRE: begin
					result.page_updated = 1'b1;
					result.free_space   = clamp_space(fr_c + amt_c);
					if (yg_a >= item.xact_id) begin
						result.reserved = clamp_space(rs_c + amt_c);
						if (owner) begin
							result.private_reserve = clamp_space(pr_c + amt_c);
						end
					end
				end
				default: begin
					result.page_updated = stale;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/page_space_reservation.sv -----
// Page space reservation unit. Takes one transaction per clock on the input channel
// when the output is not stalled and returns one result transaction for each, in
// order. The path is an input register, one pass of compare and add/subtract logic,
// and a result register; the cached minimum active transaction id is updated as
// each item moves from the input register into the result register, so every item
// sees the cache left by the one before it. No configuration and no start-up sweep:
// the block is ready as soon as reset is released.
module page_space_reservation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic [psr_pkg::XACT_BITS-1:0]     xact_id,
	input  logic [psr_pkg::SPACE_W-1:0]       amount,
	input  logic [psr_pkg::SPACE_W-1:0]       amount_nonreserved,
	input  logic [psr_pkg::SPACE_W-1:0]       free_space_in,
	input  logic [psr_pkg::SPACE_W-1:0]       reserved_in,
	input  logic [psr_pkg::SPACE_W-1:0]       private_reserve_in,
	input  logic [psr_pkg::XACT_BITS-1:0]     youngest_in,
	input  logic [psr_pkg::XACT_BITS-1:0]     min_active_xact,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [psr_pkg::SPACE_W-1:0]       free_space_out,
	output logic [psr_pkg::SPACE_W-1:0]       reserved_out,
	output logic [psr_pkg::SPACE_W-1:0]       private_reserve_out,
	output logic [psr_pkg::XACT_BITS-1:0]     youngest_out,
	output logic                              alloc_ok,
	output logic                              page_updated
);
	import psr_pkg::*;

	logic                 item_valid_s1;
	psr_item_t            item_s1;
	logic                 out_valid_q;
	psr_result_t          result_q;
	logic [XACT_BITS-1:0] cache_min_q;
	logic [XACT_BITS-1:0] cache_min_nxt;
	psr_result_t          result_nxt;
	logic                 advance;
	logic                 in_fire;

	// The input register moves on whenever the result register is free or being emptied
	assign advance  = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.action             <= action;
			item_s1.xact_id            <= xact_id;
			item_s1.amount             <= amount;
			item_s1.amount_nonreserved <= amount_nonreserved;
			item_s1.free_space         <= free_space_in;
			item_s1.reserved           <= reserved_in;
			item_s1.private_reserve    <= private_reserve_in;
			item_s1.youngest           <= youngest_in;
			item_s1.min_active_xact    <= min_active_xact;
		end
	end

	// Header update logic
	psr_calc u_calc (
		.item          (item_s1),
		.cache_min     (cache_min_q),
		.result        (result_nxt),
		.cache_min_nxt (cache_min_nxt)
	);

	// Cached minimum active id and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_min_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cache_min_q <= cache_min_nxt;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= item_valid_s1;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid           = out_valid_q;
	assign free_space_out      = result_q.free_space;
	assign reserved_out        = result_q.reserved;
	assign private_reserve_out = result_q.private_reserve;
	assign youngest_out        = result_q.youngest;
	assign alloc_ok            = result_q.alloc_ok;
	assign page_updated        = result_q.page_updated;

endmodule

// ----- rtl/core/psr_checker.sv -----
module psr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [psr_pkg::SPACE_W-1:0]   free_space_out,
	input logic [psr_pkg::SPACE_W-1:0]   reserved_out,
	input logic [psr_pkg::SPACE_W-1:0]   private_reserve_out,
	input logic [psr_pkg::XACT_BITS-1:0] youngest_out,
	input logic                          alloc_ok,
	input logic                          page_updated
);

	// A stalled result holds its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(free_space_out)
			&& $stable(reserved_out) && $stable(private_reserve_out)
			&& $stable(youngest_out) && $stable(alloc_ok) && $stable(page_updated))
		else $error("stalled result changed or dropped");

	// With the output side empty, the block must be able to take a transaction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while the output is empty");

	// A new result follows its transaction through the input and result registers.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching accepted transaction");

endmodule

bind page_space_reservation psr_checker u_psr_checker (.*);
